>>> hdl/line_pixel_generator_unit_macros.svh
// ----------------------------------------------------------------------------
// Line pixel generator assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_GENERATOR_UNIT_MACROS_SVH
`define LINE_PIXEL_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define LPG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// Types and constants shared by the line pixel generator modules.
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 1;
  localparam int COLOR_BITS = 16;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ERR_BITS-1:0]   err_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [1:0]            dir_t;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam dir_t DIR_NONE  = 2'd0;
  localparam dir_t DIR_PLUS  = 2'd1;
  localparam dir_t DIR_MINUS = 2'd3;

  typedef struct packed {
    logic   opcode;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t pen_color;
  } item_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    color_t point_color;
    logic   point_valid;
    logic   last_point;
  } result_t;

endpackage

>>> hdl/lpg_in_reg.sv
// ----------------------------------------------------------------------------
// lpg_in_reg
// Input request register; refills in the same cycle it is drained.
// ----------------------------------------------------------------------------
module lpg_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lpg_pkg::item_t in_item,
  input  logic          take,
  output logic          item_valid,
  output lpg_pkg::item_t item
);
  import lpg_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take)
      valid_nxt = 1'b0;
    if (in_valid && in_ready)
      valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

>>> hdl/lpg_core.sv
// ----------------------------------------------------------------------------
// lpg_core
// Line state and per-request step: setup and start point on start, point and error update on advance.
// ----------------------------------------------------------------------------
module lpg_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  lpg_pkg::item_t   item,
  output lpg_pkg::result_t res
);
  import lpg_pkg::*;

  coord_t cur_col_r, cur_col_nxt;
  coord_t cur_row_r, cur_row_nxt;
  dir_t   col_dir_r, col_dir_nxt;
  dir_t   row_dir_r, row_dir_nxt;
  coord_t abs_dx_r, abs_dx_nxt;
  coord_t abs_dy_r, abs_dy_nxt;
  coord_t major_len_r, major_len_nxt;
  err_t   col_err_r, col_err_nxt;
  err_t   row_err_r, row_err_nxt;
  err_t   points_left_r, points_left_nxt;
  color_t held_color_r, held_color_nxt;
  logic   busy_r, busy_nxt;

  dir_t   s_col_dir, s_row_dir;
  coord_t s_dx, s_dy, s_major;
  err_t   col_sum, row_sum, pl_dec;
  logic   col_step, row_step;

  function automatic dir_t axis_dir(input coord_t from, input coord_t to);
    if (to > from)
      return DIR_PLUS;
    else if (to == from)
      return DIR_NONE;
    else
      return DIR_MINUS;
  endfunction

  function automatic coord_t axis_mag(input coord_t from, input coord_t to);
    if (to > from)
      return to - from;
    else
      return from - to;
  endfunction

  function automatic coord_t move_coord(input coord_t pos, input dir_t dir);
    case (dir)
      DIR_PLUS:  return pos + coord_t'(1);
      DIR_MINUS: return pos - coord_t'(1);
      default:   return pos;
    endcase
  endfunction

  assign s_col_dir = axis_dir(item.start_x, item.end_x);
  assign s_row_dir = axis_dir(item.start_y, item.end_y);
  assign s_dx      = axis_mag(item.start_x, item.end_x);
  assign s_dy      = axis_mag(item.start_y, item.end_y);
  assign s_major   = (s_dx > s_dy) ? s_dx : s_dy;

  assign col_sum  = col_err_r + {1'b0, abs_dx_r};
  assign row_sum  = row_err_r + {1'b0, abs_dy_r};
  assign col_step = col_sum > {1'b0, major_len_r};
  assign row_step = row_sum > {1'b0, major_len_r};
  assign pl_dec   = (points_left_r != '0) ? points_left_r - err_t'(1) : '0;

  always_comb begin
    cur_col_nxt     = cur_col_r;
    cur_row_nxt     = cur_row_r;
    col_dir_nxt     = col_dir_r;
    row_dir_nxt     = row_dir_r;
    abs_dx_nxt      = abs_dx_r;
    abs_dy_nxt      = abs_dy_r;
    major_len_nxt   = major_len_r;
    col_err_nxt     = col_err_r;
    row_err_nxt     = row_err_r;
    points_left_nxt = points_left_r;
    held_color_nxt  = held_color_r;
    busy_nxt        = busy_r;
    res             = '0;

    if (item.opcode == OP_START) begin
      // errors start at each delta; the first update steps an axis whose doubled delta exceeds the major length
      res.point_x     = item.start_x;
      res.point_y     = item.start_y;
      res.point_color = item.pen_color;
      res.point_valid = 1'b1;
      cur_col_nxt     = item.start_x;
      cur_row_nxt     = item.start_y;
      col_dir_nxt     = s_col_dir;
      row_dir_nxt     = s_row_dir;
      abs_dx_nxt      = s_dx;
      abs_dy_nxt      = s_dy;
      major_len_nxt   = s_major;
      col_err_nxt     = {1'b0, s_dx};
      row_err_nxt     = {1'b0, s_dy};
      points_left_nxt = {1'b0, s_major} + err_t'(1);
      held_color_nxt  = item.pen_color;
      busy_nxt        = 1'b1;
    end else if (busy_r) begin
      res.point_x     = cur_col_r;
      res.point_y     = cur_row_r;
      res.point_color = held_color_r;
      res.point_valid = 1'b1;
      res.last_point  = (pl_dec == '0);
      points_left_nxt = pl_dec;
      busy_nxt        = (pl_dec != '0);
      col_err_nxt     = col_step ? col_sum - {1'b0, major_len_r} : col_sum;
      row_err_nxt     = row_step ? row_sum - {1'b0, major_len_r} : row_sum;
      cur_col_nxt     = col_step ? move_coord(cur_col_r, col_dir_r) : cur_col_r;
      cur_row_nxt     = row_step ? move_coord(cur_row_r, row_dir_r) : cur_row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r     <= '0;
      cur_row_r     <= '0;
      col_dir_r     <= DIR_NONE;
      row_dir_r     <= DIR_NONE;
      abs_dx_r      <= '0;
      abs_dy_r      <= '0;
      major_len_r   <= '0;
      col_err_r     <= '0;
      row_err_r     <= '0;
      points_left_r <= '0;
      held_color_r  <= '0;
      busy_r        <= 1'b0;
    end else if (fire) begin
      cur_col_r     <= cur_col_nxt;
      cur_row_r     <= cur_row_nxt;
      col_dir_r     <= col_dir_nxt;
      row_dir_r     <= row_dir_nxt;
      abs_dx_r      <= abs_dx_nxt;
      abs_dy_r      <= abs_dy_nxt;
      major_len_r   <= major_len_nxt;
      col_err_r     <= col_err_nxt;
      row_err_r     <= row_err_nxt;
      points_left_r <= points_left_nxt;
      held_color_r  <= held_color_nxt;
      busy_r        <= busy_nxt;
    end
  end

endmodule

>>> hdl/lpg_out_reg.sv
// ----------------------------------------------------------------------------
// lpg_out_reg
// Result register; loads a new result in the cycle the held one is taken.
// ----------------------------------------------------------------------------
module lpg_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  lpg_pkg::result_t res,
  output logic             slot_free,
  output logic             out_valid,
  input  logic             out_ready,
  output lpg_pkg::result_t out_res
);
  import lpg_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready)
      valid_nxt = 1'b0;
    if (res_valid && slot_free)
      valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && slot_free) begin
      res_r <= res;
    end
  end

endmodule

>>> hdl/line_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// line_pixel_generator_unit
// Bresenham-style line pixel generator: one result per request.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    opcode, start_x, start_y, end_x, end_y, pen_color
//   out      out_valid/out_ready  point_x, point_y, point_color, point_valid,
//                                 last_point
//
// One request per cycle while the output is not stalled; each request passes
// through the input register, then the line step into the result register.
// Synchronous active-low reset clears the line state to idle and empties
// both registers.
// A stalled output holds its result; the input register still drains into
// the result register in the cycle the result is taken.
// ----------------------------------------------------------------------------
module line_pixel_generator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  lpg_pkg::coord_t     in_start_x,
  input  lpg_pkg::coord_t     in_start_y,
  input  lpg_pkg::coord_t     in_end_x,
  input  lpg_pkg::coord_t     in_end_y,
  input  lpg_pkg::color_t     in_pen_color,
  output logic                out_valid,
  input  logic                out_ready,
  output lpg_pkg::coord_t     out_point_x,
  output lpg_pkg::coord_t     out_point_y,
  output lpg_pkg::color_t     out_point_color,
  output logic                out_point_valid,
  output logic                out_last_point
);
  import lpg_pkg::*;

  item_t   in_item, item;
  result_t res, out_res;
  logic    item_valid, slot_free, fire;

  assign in_item.opcode    = in_opcode;
  assign in_item.start_x   = in_start_x;
  assign in_item.start_y   = in_start_y;
  assign in_item.end_x     = in_end_x;
  assign in_item.end_y     = in_end_y;
  assign in_item.pen_color = in_pen_color;

  assign fire = item_valid && slot_free;

  lpg_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  lpg_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .res   (res)
  );

  lpg_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_point_x     = out_res.point_x;
  assign out_point_y     = out_res.point_y;
  assign out_point_color = out_res.point_color;
  assign out_point_valid = out_res.point_valid;
  assign out_last_point  = out_res.last_point;

endmodule

>>> hdl/lpg_checker.sv
// ----------------------------------------------------------------------------
// lpg_checker
// Port-level checks for the line pixel generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_pixel_generator_unit_macros.svh"

module lpg_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input lpg_pkg::coord_t out_point_x,
  input lpg_pkg::coord_t out_point_y,
  input lpg_pkg::color_t out_point_color,
  input logic            out_point_valid,
  input logic            out_last_point
);
  import lpg_pkg::*;

  `LPG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_point_x) && $stable(out_point_y) &&
    $stable(out_point_color) && $stable(out_point_valid) && $stable(out_last_point),
    "stalled result changed")
  `LPG_ASSERT_SAME(a_last_valid, clk, rst_n, out_valid && out_last_point,
    out_point_valid, "last point flagged on an empty result")
  `LPG_ASSERT_SAME(a_idle_zero, clk, rst_n, out_valid && !out_point_valid,
    out_point_x == '0 && out_point_y == '0 && out_point_color == '0,
    "idle result carries data")
  `LPG_ASSERT_SAME(a_ready_empty, clk, rst_n, !out_valid, in_ready,
    "input stalled with empty output")

endmodule

bind line_pixel_generator_unit lpg_checker u_lpg_checker (.*);
